// File: design/lph_pkg.sv
// ---------------------------------------------------------------------------
// lph_pkg
// Shared types, codes and constants for the linear-probing hash table.
// ---------------------------------------------------------------------------
package lph_pkg;

    // Default number of slots
    localparam int TABLE_SIZE_DEF = 251;

    // FNV-1a single-step constants
    localparam logic [31:0] FNV_OFFSET = 32'h811C_9DC5;
    localparam logic [31:0] FNV_PRIME  = 32'h0100_0193;

    // Bits of the hash consumed per modulo stage
    localparam int DIG_W = 4;

    // Depth of the queue between front and back
    localparam int QUEUE_DEPTH = 4;

    // Slot memory word: stored hash over stored value
    localparam int SLOT_W = 64;

    // Command codes
    localparam logic [1:0] CMD_FIND   = 2'd0;
    localparam logic [1:0] CMD_INSERT = 2'd1;
    localparam logic [1:0] CMD_ACCESS = 2'd2;

    // Status codes
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_MISS = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    // Request as it travels from front to back
    typedef struct packed {
        logic [1:0]  cmd;
        logic [31:0] h;
        logic [31:0] delta;
    } req_t;

endpackage

// File: design/lph_ram.sv
// ---------------------------------------------------------------------------
// lph_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ---------------------------------------------------------------------------
module lph_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [0:DEPTH-1];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // Registered read, holds when not enabled
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: design/lph_front.sv
// ---------------------------------------------------------------------------
// lph_front
// Front end: hashes the key and reduces the hash modulo the table size in a
// pipeline of digit stages, then hands the request to the queue.
// ---------------------------------------------------------------------------
module lph_front import lph_pkg::*; #(
    parameter int TABLE_SIZE = TABLE_SIZE_DEF,
    localparam int IDX_W = $clog2(TABLE_SIZE)
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               hold,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         cmd,
    input  logic signed [31:0] key,
    input  logic signed [31:0] delta,
    input  logic               q_full,
    output logic               q_push,
    output req_t               q_req,
    output logic [IDX_W-1:0]   q_idx
);

    localparam int NDIG = 32 / DIG_W;
    localparam int RW   = IDX_W + DIG_W;

    logic [NDIG:0]    vld_reg;
    req_t             req_reg [0:NDIG];
    logic [IDX_W-1:0] rem_reg [1:NDIG];
    logic [IDX_W-1:0] rem_in  [1:NDIG];
    logic [IDX_W-1:0] rem_next [1:NDIG];
    logic [31:0]      hash_in;
    logic             adv;

    // One radix-2^DIG_W step of remainder recurrence
    function automatic logic [IDX_W-1:0] rem_step(input logic [IDX_W-1:0] r,
                                                  input logic [DIG_W-1:0] d);
        logic [RW-1:0] t;
        logic [RW-1:0] res;
        t   = {r, d};
        res = t;
        for (int k = 1; k < (1 << DIG_W); k++)
        begin
            if (t >= RW'(k * TABLE_SIZE))
            begin
                res = t - RW'(k * TABLE_SIZE);
            end
        end
        return res[IDX_W-1:0];
    endfunction

    // Whole pipeline moves unless the last stage is blocked by a full queue
    assign adv      = !(vld_reg[NDIG] && q_full);
    assign in_stall = !adv || hold;

    // FNV-1a step, wraps at 32 bits
    assign hash_in = (FNV_OFFSET ^ $unsigned(key)) * FNV_PRIME;

    // Remainder of each digit stage
    always_comb
    begin
        rem_in[1] = '0;
        for (int s = 2; s <= NDIG; s++)
        begin
            rem_in[s] = rem_reg[s-1];
        end
        for (int s = 1; s <= NDIG; s++)
        begin
            rem_next[s] = rem_step(rem_in[s],
                                   req_reg[s-1].h[DIG_W*(NDIG-s+1)-1 -: DIG_W]);
        end
    end

    // Stage valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[NDIG-1:0], in_valid && !hold};
        end
    end

    // Stage payload
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            req_reg[0].cmd   <= cmd;
            req_reg[0].h     <= hash_in;
            req_reg[0].delta <= $unsigned(delta);
            for (int s = 1; s <= NDIG; s++)
            begin
                req_reg[s] <= req_reg[s-1];
                rem_reg[s] <= rem_next[s];
            end
        end
    end

    assign q_push = vld_reg[NDIG] && adv;
    assign q_req  = req_reg[NDIG];
    assign q_idx  = rem_reg[NDIG];

endmodule

// File: design/lph_fifo.sv
// ---------------------------------------------------------------------------
// lph_fifo
// Short first-word-fall-through queue between the front and back ends.
// ---------------------------------------------------------------------------
module lph_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             full,
    output logic             empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] buf_reg [0:DEPTH-1];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             do_push;
    logic             do_pop;

    assign full    = (cnt_reg == CNT_W'(DEPTH));
    assign empty   = (cnt_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = buf_reg[rd_ptr_reg];

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    // Storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            buf_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

// File: design/lph_back.sv
// ---------------------------------------------------------------------------
// lph_back
// Back end: clears the slot memory after reset, then probes slots one read
// per cycle for each queued request and writes the result register.
// ---------------------------------------------------------------------------
module lph_back import lph_pkg::*; #(
    parameter int TABLE_SIZE = TABLE_SIZE_DEF,
    localparam int IDX_W = $clog2(TABLE_SIZE)
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_empty,
    output logic               q_pop,
    input  req_t               q_req,
    input  logic [IDX_W-1:0]   q_idx,
    output logic               clearing,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [1:0]         status,
    output logic signed [31:0] value,
    output logic [7:0]         slot
);

    localparam logic [1:0] S_CLEAR = 2'd0;
    localparam logic [1:0] S_IDLE  = 2'd1;
    localparam logic [1:0] S_PROBE = 2'd2;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_SIZE - 1);

    logic [1:0]        state_reg,  state_next;
    logic [IDX_W-1:0]  clr_reg,    clr_next;
    logic [IDX_W-1:0]  idx_reg,    idx_next;
    logic [IDX_W-1:0]  cnt_reg,    cnt_next;
    req_t              req_reg,    req_next;
    logic              out_valid_reg, out_valid_next;
    logic [1:0]        status_reg, status_next;
    logic [31:0]       value_reg,  value_next;
    logic [7:0]        slot_reg,   slot_next;

    logic              ram_we;
    logic [IDX_W-1:0]  ram_waddr;
    logic [SLOT_W-1:0] ram_wdata;
    logic              ram_re;
    logic [IDX_W-1:0]  ram_raddr;
    logic [SLOT_W-1:0] ram_rdata;

    logic [31:0]       stored_h;
    logic [31:0]       stored_v;
    logic              match;
    logic              hit;
    logic              last;
    logic              out_free;
    logic [IDX_W-1:0]  idx_inc;
    logic [31:0]       idx_ext;
    logic [31:0]       acc_val;

    lph_ram #(
        .WIDTH (SLOT_W),
        .DEPTH (TABLE_SIZE)
    ) u_slots (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Probe compare
    assign stored_h = ram_rdata[SLOT_W-1:32];
    assign stored_v = ram_rdata[31:0];
    assign match    = (stored_h == req_reg.h);
    assign hit      = match || (stored_h == '0);
    assign last     = (cnt_reg == LAST_IDX);
    assign idx_inc  = (idx_reg == LAST_IDX) ? '0 : idx_reg + 1'b1;
    assign idx_ext  = 32'(idx_reg);
    assign acc_val  = (match ? stored_v : 32'd0) + req_reg.delta;
    assign out_free = !out_valid_reg || !out_stall;

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        idx_next       = idx_reg;
        cnt_next       = cnt_reg;
        req_next       = req_reg;
        out_valid_next = out_valid_reg && out_stall;
        status_next    = status_reg;
        value_next     = value_reg;
        slot_next      = slot_reg;
        q_pop          = 1'b0;
        ram_we         = 1'b0;
        ram_waddr      = idx_reg;
        ram_wdata      = '0;
        ram_re         = 1'b0;
        ram_raddr      = idx_reg;

        unique case (state_reg)
            // Sweep the memory to empty after reset
            S_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                if (clr_reg == LAST_IDX)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    clr_next = clr_reg + 1'b1;
                end
            end

            // Take a request and read its home slot
            S_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop      = 1'b1;
                    req_next   = q_req;
                    idx_next   = q_idx;
                    cnt_next   = '0;
                    ram_re     = 1'b1;
                    ram_raddr  = q_idx;
                    state_next = S_PROBE;
                end
            end

            // Check a slot; stop on empty, match or a full lap
            S_PROBE:
            begin
                if (hit || last)
                begin
                    if (out_free)
                    begin
                        out_valid_next = 1'b1;
                        status_next    = ST_OK;
                        value_next     = '0;
                        slot_next      = '0;
                        state_next     = S_IDLE;
                        unique case (req_reg.cmd)
                            CMD_INSERT:
                            begin
                                if (hit)
                                begin
                                    ram_we    = 1'b1;
                                    ram_wdata = {req_reg.h, 32'd0};
                                    slot_next = idx_ext[7:0];
                                end
                                else
                                begin
                                    status_next = ST_FULL;
                                end
                            end
                            CMD_ACCESS:
                            begin
                                if (hit)
                                begin
                                    ram_we     = 1'b1;
                                    ram_wdata  = {req_reg.h, acc_val};
                                    value_next = acc_val;
                                    slot_next  = idx_ext[7:0];
                                end
                                else
                                begin
                                    status_next = ST_FULL;
                                end
                            end
                            default:
                            begin
                                // find, and the unused code
                                if (match)
                                begin
                                    value_next = stored_v;
                                    slot_next  = idx_ext[7:0];
                                end
                                else
                                begin
                                    status_next = ST_MISS;
                                end
                            end
                        endcase
                    end
                end
                else
                begin
                    idx_next  = idx_inc;
                    cnt_next  = cnt_reg + 1'b1;
                    ram_re    = 1'b1;
                    ram_raddr = idx_inc;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        idx_reg    <= idx_next;
        cnt_reg    <= cnt_next;
        req_reg    <= req_next;
        status_reg <= status_next;
        value_reg  <= value_next;
        slot_reg   <= slot_next;
    end

    assign clearing  = (state_reg == S_CLEAR);
    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign value     = $signed(value_reg);
    assign slot      = slot_reg;

endmodule

// File: design/linear_probe_hash_table.sv
// ---------------------------------------------------------------------------
// linear_probe_hash_table
// Open-addressing hash table with FNV-1a hashed 32-bit keys and linear probing.
// ---------------------------------------------------------------------------
// Requests (find, insert, access) enter a front pipeline that hashes the key
// and reduces it modulo TABLE_SIZE, one item per cycle while neither the
// queue is full nor the slot memory is being cleared. A four-entry queue
// feeds the back end, which reads one slot per cycle from a single slot
// memory and handles one request at a time, probing until it meets an
// empty slot, a matching slot or a full lap. After reset the back end
// clears the slot memory, during which req_stall stays high. One response
// per request, in request order; the response register lets the next
// request proceed while a response waits to be taken.
// ---------------------------------------------------------------------------
module linear_probe_hash_table import lph_pkg::*; #(
    parameter int TABLE_SIZE = TABLE_SIZE_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_stall,
    input  logic [1:0]         cmd,
    input  logic signed [31:0] key,
    input  logic signed [31:0] delta,
    output logic               rsp_valid,
    input  logic               rsp_stall,
    output logic [1:0]         status,
    output logic signed [31:0] value,
    output logic [7:0]         slot
);

    localparam int IDX_W  = $clog2(TABLE_SIZE);
    localparam int ENTRY_W = $bits(req_t) + IDX_W;

    logic               clearing;
    logic               q_push;
    logic               q_pop;
    logic               q_full;
    logic               q_empty;
    req_t               f_req;
    logic [IDX_W-1:0]   f_idx;
    logic [ENTRY_W-1:0] q_rdata;
    req_t               b_req;
    logic [IDX_W-1:0]   b_idx;

    // Hash and home-slot pipeline
    lph_front #(
        .TABLE_SIZE (TABLE_SIZE)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .hold     (clearing),
        .in_valid (req_valid),
        .in_stall (req_stall),
        .cmd      (cmd),
        .key      (key),
        .delta    (delta),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_req    (f_req),
        .q_idx    (f_idx)
    );

    // Decoupling queue
    lph_fifo #(
        .WIDTH (ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .wdata ({f_req, f_idx}),
        .pop   (q_pop),
        .rdata (q_rdata),
        .full  (q_full),
        .empty (q_empty)
    );

    assign b_req = q_rdata[ENTRY_W-1:IDX_W];
    assign b_idx = q_rdata[IDX_W-1:0];

    // Probe engine and slot memory
    lph_back #(
        .TABLE_SIZE (TABLE_SIZE)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .q_pop     (q_pop),
        .q_req     (b_req),
        .q_idx     (b_idx),
        .clearing  (clearing),
        .out_valid (rsp_valid),
        .out_stall (rsp_stall),
        .status    (status),
        .value     (value),
        .slot      (slot)
    );

endmodule

// File: design/lph_checker.sv
// ---------------------------------------------------------------------------
// lph_checker
// Port-level checks for the hash table, bound to the top level.
// ---------------------------------------------------------------------------
module lph_checker import lph_pkg::*; #(
    parameter int TABLE_SIZE = TABLE_SIZE_DEF
) (
    input logic               clk,
    input logic               rst_n,
    input logic               req_stall,
    input logic               rsp_valid,
    input logic               rsp_stall,
    input logic [1:0]         status,
    input logic signed [31:0] value,
    input logic [7:0]         slot
);

    // A stalled response holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(status) && $stable(value)
            && $stable(slot))
        else $error("response changed while stalled");

    // Failures report zero value and slot zero
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (status != ST_OK) |-> (value == 0) && (slot == 8'd0))
        else $error("failed operation with non-zero value or slot");

    // A successful slot lies inside the table
    a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (status == ST_OK) |-> (TABLE_SIZE > 256) || (int'(slot) < TABLE_SIZE))
        else $error("slot index beyond table");

    // Clearing pass blocks requests right after reset
    a_clear_stall: assert property (@(posedge clk) disable iff (!rst_n)
        $past(!rst_n) |-> req_stall)
        else $error("request taken during clearing pass");

endmodule

bind linear_probe_hash_table lph_checker #(
    .TABLE_SIZE (TABLE_SIZE)
) u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .status    (status),
    .value     (value),
    .slot      (slot)
);

// File: verif/linear_probe_hash_table_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// linear_probe_hash_table_tb
// Self-checking bench for the linear-probing hash table.
// ---------------------------------------------------------------------------
// A clocked driver presents requests from a queue that the stimulus process
// fills; on each request transfer a shadow copy of the table works out the
// response, which the monitor compares field by field on each response
// transfer. A short directed run covers field extremes, every command,
// probe wrap-round and the zero-hash key; random traffic, mostly of fresh
// keys with stored ones reused, fills the table until it reports full. Four
// phases vary idling on both sides, draining all responses between phases.
// ---------------------------------------------------------------------------
module linear_probe_hash_table_tb;
    import lph_pkg::*;

    localparam int          TABLE_SIZE    = TABLE_SIZE_DEF;
    localparam logic [31:0] SLOTS_U       = TABLE_SIZE;
    // The offset cancels in the xor, so this key hashes to zero
    localparam logic [31:0] ZERO_HASH_KEY = FNV_OFFSET;
    localparam logic [1:0]  CMD_UNUSED    = 2'd3;
    localparam logic [31:0] WORD_MAX      = 32'h7FFF_FFFF;
    localparam logic [31:0] WORD_MIN      = 32'h8000_0000;
    localparam int          PHASE_ITEMS   = 170;
    localparam int          FRESH_PCT     = 65;
    localparam int          TAIL_CYCLES   = 300;
    localparam int          CYCLE_LIMIT   = 1_000_000;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [31:0] key;
        logic [31:0] delta;
    } request_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] value;
        logic [7:0]  slot;
    } answer_t;

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               req_valid = 1'b0;
    logic               req_stall;
    logic [1:0]         cmd       = CMD_FIND;
    logic signed [31:0] key       = '0;
    logic signed [31:0] delta     = '0;
    logic               rsp_valid;
    logic               rsp_stall = 1'b0;
    logic [1:0]         status;
    logic signed [31:0] value;
    logic [7:0]         slot;

    // Shadow of the table contents
    logic [31:0] shadow_hash    [TABLE_SIZE] = '{default: '0};
    logic [31:0] shadow_value   [TABLE_SIZE] = '{default: '0};
    bit          shadow_written [TABLE_SIZE] = '{default: 1'b0};

    request_t    pending_reqs[$];
    answer_t     expected_answers[$];
    logic [31:0] known_keys[$];

    int send_idle_pct = 0;
    int rsp_stall_pct = 0;
    int n_fail        = 0;
    int cycle_count   = 0;

    linear_probe_hash_table dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .cmd       (cmd),
        .key       (key),
        .delta     (delta),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .status    (status),
        .value     (value),
        .slot      (slot)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ---------------------------------------------------------------------
    // Table prediction
    // ---------------------------------------------------------------------
    function automatic logic [31:0] fnv_step(logic [31:0] k);
        return (FNV_OFFSET ^ k) * FNV_PRIME;
    endfunction

    // Slot where probing stops for hash h, or -1 after a full sweep
    function automatic int probe_stop(logic [31:0] h);
        int idx;
        idx = int'(h % SLOTS_U);
        for (int n = 0; n < TABLE_SIZE; n++)
        begin
            if (shadow_hash[idx] == '0 || shadow_hash[idx] == h)
                return idx;
            idx = (idx + 1) % TABLE_SIZE;
        end
        return -1;
    endfunction

    function automatic answer_t apply_request(request_t r);
        logic [31:0] h;
        int          pos;
        answer_t     ans;
        h   = fnv_step(r.key);
        pos = probe_stop(h);
        ans = '{status: ST_OK, value: '0, slot: '0};
        case (r.cmd)
            CMD_INSERT:
            begin
                if (pos < 0)
                    ans.status = ST_FULL;
                else
                begin
                    shadow_hash[pos]    = h;
                    shadow_value[pos]   = '0;
                    shadow_written[pos] = 1'b1;
                    ans.slot            = 8'(pos);
                end
            end
            CMD_ACCESS:
            begin
                if (pos < 0)
                    ans.status = ST_FULL;
                else
                begin
                    if (shadow_hash[pos] != h)
                    begin
                        shadow_hash[pos]    = h;
                        shadow_value[pos]   = '0;
                        shadow_written[pos] = 1'b1;
                    end
                    shadow_value[pos] = shadow_value[pos] + r.delta;
                    ans.value         = shadow_value[pos];
                    ans.slot          = 8'(pos);
                end
            end
            // find, and the unused code which behaves as find
            default:
            begin
                if (pos >= 0 && shadow_hash[pos] == h)
                begin
                    ans.value = shadow_value[pos];
                    ans.slot  = 8'(pos);
                end
                else
                    ans.status = ST_MISS;
            end
        endcase
        return ans;
    endfunction

    // ---------------------------------------------------------------------
    // Request driver: one transfer per accepted request, random idle gaps
    // ---------------------------------------------------------------------
    always @(posedge clk)
    begin : drive_req
        logic     next_valid;
        request_t r;
        if (rst_n)
        begin
            next_valid = req_valid;
            if (req_valid && !req_stall)
            begin
                expected_answers.push_back(apply_request('{cmd, key, delta}));
                next_valid = 1'b0;
            end
            if (!next_valid && pending_reqs.size() != 0
                && $urandom_range(99) >= send_idle_pct)
            begin
                r = pending_reqs.pop_front();
                cmd   <= r.cmd;
                key   <= r.key;
                delta <= r.delta;
                next_valid = 1'b1;
            end
            req_valid <= next_valid;
        end
    end

    // ---------------------------------------------------------------------
    // Response monitor and receiver stalls
    // ---------------------------------------------------------------------
    always @(posedge clk)
    begin : check_rsp
        answer_t exp_ans;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (expected_answers.size() == 0)
            begin
                $error("response with none outstanding: status %0d value %0h slot %0d",
                       status, value, slot);
                n_fail++;
            end
            else
            begin
                exp_ans = expected_answers.pop_front();
                if (status !== exp_ans.status)
                begin
                    $error("status mismatch: expected %0d, got %0d", exp_ans.status, status);
                    n_fail++;
                end
                if (value !== exp_ans.value)
                begin
                    $error("value mismatch: expected %0h, got %0h", exp_ans.value, value);
                    n_fail++;
                end
                if (slot !== exp_ans.slot)
                begin
                    $error("slot mismatch: expected %0d, got %0d", exp_ans.slot, slot);
                    n_fail++;
                end
            end
        end
        rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("[linear_probe_hash_table] ERROR");
            $finish;
        end
    end

    // ---------------------------------------------------------------------
    // Stimulus
    // ---------------------------------------------------------------------
    // Wait until every queued request has transferred, and optionally every
    // response too; sampled on the falling edge so the shadow is settled
    task automatic wait_for_quiet(bit all_answers);
        do
            @(negedge clk);
        while (pending_reqs.size() != 0 || req_valid
               || (all_answers && expected_answers.size() != 0));
    endtask

    function automatic logic [31:0] extreme_word();
        case ($urandom_range(3))
            0:       return '0;
            1:       return '1;
            2:       return WORD_MAX;
            default: return WORD_MIN;
        endcase
    endfunction

    // Random key whose probe starts at slot s
    function automatic logic [31:0] key_at_start(int s);
        logic [31:0] k;
        do
            k = $urandom();
        while (int'(fnv_step(k) % SLOTS_U) != s || k == ZERO_HASH_KEY);
        return k;
    endfunction

    task automatic push_item(logic [1:0] c, logic [31:0] k, logic [31:0] d);
        int pos;
        // A find or access by the zero-hash key on an empty slot whose value
        // was never written has no defined answer: turn it into an insert
        if (k == ZERO_HASH_KEY && c != CMD_INSERT)
        begin
            wait_for_quiet(1'b0);
            pos = probe_stop('0);
            if (pos >= 0 && !shadow_written[pos])
                c = CMD_INSERT;
        end
        if ((c == CMD_INSERT || c == CMD_ACCESS) && k != ZERO_HASH_KEY)
            known_keys.push_back(k);
        pending_reqs.push_back('{c, k, d});
    endtask

    task automatic random_item();
        logic [31:0] k;
        logic [31:0] d;
        logic [1:0]  c;
        bit          fresh;
        int          sel;
        fresh = (known_keys.size() == 0) || ($urandom_range(99) < FRESH_PCT);
        if ($urandom_range(99) < 4)
            k = ZERO_HASH_KEY;
        else if (fresh)
            k = ($urandom_range(19) == 0) ? extreme_word() : 32'($urandom());
        else
            k = known_keys[$urandom_range(known_keys.size() - 1)];
        sel = $urandom_range(19);
        // new keys are mostly stored, known keys mostly looked up or counted
        if (fresh)
            c = (sel < 4) ? CMD_FIND : (sel < 11) ? CMD_INSERT :
                (sel < 19) ? CMD_ACCESS : CMD_UNUSED;
        else
            c = (sel < 7) ? CMD_FIND : (sel < 10) ? CMD_INSERT :
                (sel < 18) ? CMD_ACCESS : CMD_UNUSED;
        d = ($urandom_range(9) == 0) ? extreme_word() : 32'($urandom());
        push_item(c, k, d);
    endtask

    initial
    begin : stimulus
        logic [31:0] k_a;
        logic [31:0] k_b;
        logic [31:0] k_c;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: extremes, every command, counter wrap
        push_item(CMD_FIND,   '0,       '0);
        push_item(CMD_INSERT, '0,       '1);
        push_item(CMD_FIND,   '0,       '0);
        push_item(CMD_ACCESS, '0,       WORD_MAX);
        push_item(CMD_ACCESS, '0,       32'd1);
        push_item(CMD_ACCESS, '0,       WORD_MIN);
        push_item(CMD_ACCESS, '1,       '1);
        push_item(CMD_INSERT, '1,       WORD_MAX);
        push_item(CMD_FIND,   '1,       '0);
        push_item(CMD_UNUSED, '1,       '1);
        push_item(CMD_UNUSED, WORD_MAX, '0);
        push_item(CMD_ACCESS, WORD_MIN, WORD_MIN);

        // Zero-hash key sits on an empty slot without claiming it
        push_item(CMD_INSERT, ZERO_HASH_KEY, '0);
        push_item(CMD_FIND,   ZERO_HASH_KEY, '0);
        push_item(CMD_ACCESS, ZERO_HASH_KEY, 32'd5);
        push_item(CMD_UNUSED, ZERO_HASH_KEY, WORD_MAX);

        // Collisions on the last slot: the chain wraps round to slot 0
        k_a = key_at_start(TABLE_SIZE - 1);
        k_b = key_at_start(TABLE_SIZE - 1);
        k_c = key_at_start(TABLE_SIZE - 1);
        push_item(CMD_INSERT, k_a, '0);
        push_item(CMD_ACCESS, k_b, 32'd7);
        push_item(CMD_INSERT, k_c, '0);
        push_item(CMD_FIND,   k_c, '0);
        push_item(CMD_FIND,   k_b, '0);
        push_item(CMD_INSERT, ZERO_HASH_KEY, '0);
        push_item(CMD_ACCESS, ZERO_HASH_KEY, -32'sd3);
        push_item(CMD_INSERT, WORD_MAX, '1);
        push_item(CMD_FIND,   WORD_MAX, '0);

        // Random phases; the table fills and then reports full
        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0:       begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
                1:       begin send_idle_pct = 82; rsp_stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  rsp_stall_pct = 82; end
                default: begin send_idle_pct = 18; rsp_stall_pct = 18; end
            endcase
            repeat (PHASE_ITEMS) random_item();
            // hold off until every response of the phase has come back
            wait_for_quiet(1'b1);
        end

        repeat (TAIL_CYCLES) @(posedge clk);
        if (n_fail == 0 && expected_answers.size() == 0)
            $display("[linear_probe_hash_table] OK");
        else
            $display("[linear_probe_hash_table] ERROR");
        $finish;
    end

endmodule

// File: files.f
design/lph_pkg.sv
design/lph_ram.sv
design/lph_front.sv
design/lph_fifo.sv
design/lph_back.sv
design/linear_probe_hash_table.sv
design/lph_checker.sv
verif/linear_probe_hash_table_tb.sv
